// ===== design/lrcs_pkg.sv =====
// Shared constants for the radix chunk sorter.
package lrcs_pkg;

	// Fixed payload width of keys on both channels
	localparam int KEY_W = 32;

	// Default configuration of the sorter
	localparam int CHUNK_DEF      = 64;
	localparam int DIGIT_BITS_DEF = 4;
	localparam int KEY_BITS_DEF   = 32;

endpackage

// ===== design/lrcs_if.sv =====
// Valid/ready channel interfaces for unsorted keys and sorted keys.
interface lrcs_key_if;
	logic                      valid;
	logic                      ready;
	logic [lrcs_pkg::KEY_W-1:0] key;
	logic                      final_key;

	modport source (output valid, output key, output final_key, input ready);
	modport sink   (input valid, input key, input final_key, output ready);
endinterface

interface lrcs_sorted_if;
	logic                      valid;
	logic                      ready;
	logic [lrcs_pkg::KEY_W-1:0] sorted_key;
	logic                      final_out;

	modport source (output valid, output sorted_key, output final_out, input ready);
	modport sink   (input valid, input sorted_key, input final_out, output ready);
endinterface

// ===== design/lsd_radix_chunk_sorter_top.sv =====
// Top level of the LSD radix chunk sorter: key buffers, bucket memory and sequencer.
//
// Keys are loaded one per cycle into buffer A until one carries final_key or
// CHUNK keys are held; the chunk of n keys is then sorted ascending and stably
// in ceil(KEY_BITS/DIGIT_BITS) passes, each of which clears the 2^DIGIT_BITS
// bucket counters, counts digits, forms inclusive prefix sums and scatters
// keys back to front into the other buffer, before the sorted keys stream out
// one per cycle while the sink is ready, with the last one marked. The bucket
// memory and the key buffers each have a single read and a single write port.
// No keys are taken while a chunk is being sorted or read out.
module lsd_radix_chunk_sorter_top #(
	parameter int CHUNK      = lrcs_pkg::CHUNK_DEF,
	parameter int DIGIT_BITS = lrcs_pkg::DIGIT_BITS_DEF,
	parameter int KEY_BITS   = lrcs_pkg::KEY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lrcs_key_if.sink             keys,
	lrcs_sorted_if.source        sorted
);

	localparam int NB      = 1 << DIGIT_BITS;
	localparam int NPASSES = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int IW      = $clog2(CHUNK);
	localparam int CW      = $clog2(CHUNK + 1);
	localparam int BW      = DIGIT_BITS + 1;
	localparam int PW      = $clog2(NPASSES + 1);
	localparam int SHW     = $clog2(KEY_BITS);

	localparam logic [2:0] S_LOAD    = 3'd0;
	localparam logic [2:0] S_CLEAR   = 3'd1;
	localparam logic [2:0] S_COUNT   = 3'd2;
	localparam logic [2:0] S_PREFIX  = 3'd3;
	localparam logic [2:0] S_SCATTER = 3'd4;
	localparam logic [2:0] S_OUT     = 3'd5;

	// Memories
	logic [KEY_BITS-1:0]   buf_a [CHUNK];
	logic [KEY_BITS-1:0]   buf_b [CHUNK];
	logic [CW-1:0]         cnt_mem [NB];

	// Control state
	logic [2:0]            state_q;
	logic [IW-1:0]         fill_q;
	logic [CW-1:0]         n_q;
	logic [CW-1:0]         kidx_q;
	logic [BW-1:0]         bidx_q;
	logic [PW-1:0]         pass_q;
	logic [SHW-1:0]        shift_q;
	logic                  src_sel_q;
	logic [CW-1:0]         acc_q;
	logic                  vs1_q;
	logic                  vs2_q;
	logic                  pv_s1;
	logic                  fwd_v_q;
	logic                  rd_pend_q;
	logic                  out_valid_q;

	// Payload registers
	logic [KEY_BITS-1:0]   rd_a_q;
	logic [KEY_BITS-1:0]   rd_b_q;
	logic [CW-1:0]         cnt_rd_q;
	logic [DIGIT_BITS-1:0] dig_s2;
	logic [KEY_BITS-1:0]   key_s2;
	logic [DIGIT_BITS-1:0] pa_s1;
	logic [DIGIT_BITS-1:0] fwd_a_q;
	logic [CW-1:0]         fwd_d_q;
	logic                  rd_last_q;
	logic [KEY_BITS-1:0]   out_key_q;
	logic                  out_last_q;

	// Datapath signals
	logic                  in_xfer;
	logic                  chunk_end;
	logic [KEY_BITS-1:0]   kdata;
	logic [KEY_BITS-1:0]   shifted;
	logic [DIGIT_BITS-1:0] dig_s1;
	logic                  pass_phase;
	logic                  issue;
	logic                  issue_out;
	logic                  out_load;
	logic                  src_re;
	logic [CW-1:0]         kaddr_full;
	logic [IW-1:0]         kaddr;
	logic [CW-1:0]         base;
	logic [CW-1:0]         newv;
	logic [CW-1:0]         sum;
	logic                  prefix_issue;
	logic                  cnt_re;
	logic [DIGIT_BITS-1:0] cnt_raddr;
	logic                  cnt_we;
	logic [DIGIT_BITS-1:0] cnt_waddr;
	logic [CW-1:0]         cnt_wdata;
	logic                  a_we;
	logic [IW-1:0]         a_waddr;
	logic [KEY_BITS-1:0]   a_wdata;
	logic                  b_we;
	logic                  pass_done;
	logic                  scatter_wr;

	// Handshake
	assign keys.ready        = (state_q == S_LOAD);
	assign in_xfer           = keys.valid && keys.ready;
	assign chunk_end         = keys.final_key || (fill_q == IW'(CHUNK - 1));
	assign sorted.valid      = out_valid_q;
	assign sorted.sorted_key = lrcs_pkg::KEY_W'(out_key_q);
	assign sorted.final_out  = out_last_q;

	// Key read side: pick source buffer and extract the digit of this pass
	assign kdata   = src_sel_q ? rd_b_q : rd_a_q;
	assign shifted = kdata >> shift_q;
	assign dig_s1  = shifted[DIGIT_BITS-1:0];

	assign pass_phase = (state_q == S_COUNT) || (state_q == S_SCATTER);
	assign issue      = pass_phase && (kidx_q < n_q);
	assign out_load   = rd_pend_q && (!out_valid_q || sorted.ready);
	assign issue_out  = (state_q == S_OUT) && (kidx_q < n_q) && (!rd_pend_q || out_load);
	assign src_re     = issue || issue_out;
	assign kaddr_full = (state_q == S_SCATTER) ? (n_q - CW'(1) - kidx_q) : kidx_q;
	assign kaddr      = kaddr_full[IW-1:0];
	assign pass_done  = (kidx_q == n_q) && !vs1_q && !vs2_q;

	// Bucket update with forwarding of the previous cycle's write
	assign base   = (fwd_v_q && (fwd_a_q == dig_s2)) ? fwd_d_q : cnt_rd_q;
	assign newv   = (state_q == S_SCATTER) ? (base - CW'(1)) : (base + CW'(1));
	assign sum    = acc_q + cnt_rd_q;

	assign prefix_issue = (state_q == S_PREFIX) && (bidx_q < BW'(NB));
	assign cnt_re       = prefix_issue || vs1_q;
	assign cnt_raddr    = (state_q == S_PREFIX) ? bidx_q[DIGIT_BITS-1:0] : dig_s1;

	// Select the bucket memory write
	always_comb begin
		case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = bidx_q[DIGIT_BITS-1:0];
				cnt_wdata = '0;
			end
			S_PREFIX: begin
				cnt_we    = pv_s1;
				cnt_waddr = pa_s1;
				cnt_wdata = sum;
			end
			S_COUNT, S_SCATTER: begin
				cnt_we    = vs2_q;
				cnt_waddr = dig_s2;
				cnt_wdata = newv;
			end
			default: begin
				cnt_we    = 1'b0;
				cnt_waddr = dig_s2;
				cnt_wdata = newv;
			end
		endcase
	end

	// Select key buffer writes: load into A, scatter into the destination
	assign scatter_wr = (state_q == S_SCATTER) && vs2_q;
	assign a_we       = in_xfer || (scatter_wr && src_sel_q);
	assign a_waddr    = in_xfer ? fill_q : newv[IW-1:0];
	assign a_wdata    = in_xfer ? keys.key[KEY_BITS-1:0] : key_s2;
	assign b_we       = scatter_wr && !src_sel_q;

	// Key buffer A
	always_ff @(posedge clk) begin
		if (a_we) begin
			buf_a[a_waddr] <= a_wdata;
		end
		if (src_re) begin
			rd_a_q <= buf_a[kaddr];
		end
	end

	// Key buffer B
	always_ff @(posedge clk) begin
		if (b_we) begin
			buf_b[newv[IW-1:0]] <= key_s2;
		end
		if (src_re) begin
			rd_b_q <= buf_b[kaddr];
		end
	end

	// Bucket memory
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
		end
	end

	// Advance pipeline payload
	always_ff @(posedge clk) begin
		dig_s2  <= dig_s1;
		key_s2  <= kdata;
		pa_s1   <= bidx_q[DIGIT_BITS-1:0];
		fwd_a_q <= dig_s2;
		fwd_d_q <= newv;
		if (issue_out) begin
			rd_last_q <= (kidx_q == n_q - CW'(1));
		end
		if (out_load) begin
			out_key_q  <= kdata;
			out_last_q <= rd_last_q;
		end
	end

	// Sequence load, sort passes and readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			fill_q      <= '0;
			n_q         <= '0;
			kidx_q      <= '0;
			bidx_q      <= '0;
			pass_q      <= '0;
			shift_q     <= '0;
			src_sel_q   <= 1'b0;
			acc_q       <= '0;
			vs1_q       <= 1'b0;
			vs2_q       <= 1'b0;
			pv_s1       <= 1'b0;
			fwd_v_q     <= 1'b0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vs1_q   <= issue;
			vs2_q   <= vs1_q;
			fwd_v_q <= vs2_q;
			pv_s1   <= prefix_issue;

			// Hold the result until the transfer completes
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (sorted.ready) begin
				out_valid_q <= 1'b0;
			end
			rd_pend_q <= issue_out || (rd_pend_q && !out_load);

			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (chunk_end) begin
							n_q       <= CW'(fill_q) + CW'(1);
							fill_q    <= '0;
							bidx_q    <= '0;
							pass_q    <= '0;
							shift_q   <= '0;
							src_sel_q <= 1'b0;
							state_q   <= S_CLEAR;
						end else begin
							fill_q <= fill_q + IW'(1);
						end
					end
				end
				S_CLEAR: begin
					if (bidx_q == BW'(NB - 1)) begin
						bidx_q  <= '0;
						kidx_q  <= '0;
						state_q <= S_COUNT;
					end else begin
						bidx_q <= bidx_q + BW'(1);
					end
				end
				S_COUNT: begin
					if (issue) begin
						kidx_q <= kidx_q + CW'(1);
					end
					if (pass_done) begin
						bidx_q  <= '0;
						acc_q   <= '0;
						state_q <= S_PREFIX;
					end
				end
				S_PREFIX: begin
					if (prefix_issue) begin
						bidx_q <= bidx_q + BW'(1);
					end
					if (pv_s1) begin
						acc_q <= sum;
					end
					if ((bidx_q == BW'(NB)) && !pv_s1) begin
						kidx_q  <= '0;
						state_q <= S_SCATTER;
					end
				end
				S_SCATTER: begin
					if (issue) begin
						kidx_q <= kidx_q + CW'(1);
					end
					if (pass_done) begin
						src_sel_q <= !src_sel_q;
						kidx_q    <= '0;
						bidx_q    <= '0;
						if (pass_q == PW'(NPASSES - 1)) begin
							state_q <= S_OUT;
						end else begin
							pass_q  <= pass_q + PW'(1);
							shift_q <= shift_q + SHW'(DIGIT_BITS);
							state_q <= S_CLEAR;
						end
					end
				end
				S_OUT: begin
					if (issue_out) begin
						kidx_q <= kidx_q + CW'(1);
					end
					if ((kidx_q == n_q) && !rd_pend_q) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the radix chunk sorter: directed and random key chunks checked against a sort predictor.
module tb_top;

	localparam int CHUNK      = lrcs_pkg::CHUNK_DEF;
	localparam int NBKT       = 1 << lrcs_pkg::DIGIT_BITS_DEF;
	localparam int NPASS      = (lrcs_pkg::KEY_BITS_DEF + lrcs_pkg::DIGIT_BITS_DEF - 1)
		/ lrcs_pkg::DIGIT_BITS_DEF;
	localparam logic [lrcs_pkg::KEY_W-1:0] KEY_MASK =
		lrcs_pkg::KEY_W'((64'd1 << lrcs_pkg::KEY_BITS_DEF) - 64'd1);
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 500;
	localparam int N_DIR       = 23;
	localparam int N_ITEMS     = 280;

	typedef struct packed {
		logic [lrcs_pkg::KEY_W-1:0] key;
		logic                       last;
	} sorted_t;

	typedef struct packed {
		logic [lrcs_pkg::KEY_W-1:0] key;
		logic                       fin;
		logic                       typed;
		logic [lrcs_pkg::KEY_W-1:0] exp_key;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lrcs_key_if    key_ch ();
	lrcs_sorted_if sorted_ch ();

	lsd_radix_chunk_sorter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.keys   (key_ch),
		.sorted (sorted_ch)
	);

	sorted_t                    sorted_expected[$];
	logic [lrcs_pkg::KEY_W-1:0] chunk_held[$];
	int                         mismatches = 0;
	int                         results_seen = 0;
	int unsigned                cycles = 0;
	bit                         steady = 0;

	// Typed rows are single-key chunks: the key comes back alone and marked last
	dir_row_t dir_rows [N_DIR] = '{
		'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0000, 1'b1, 1'b0, 32'h0},
		'{32'hF000_0000, 1'b0, 1'b0, 32'h0},
		'{32'h0F00_0000, 1'b0, 1'b0, 32'h0},
		'{32'h00F0_0000, 1'b0, 1'b0, 32'h0},
		'{32'h000F_0000, 1'b0, 1'b0, 32'h0},
		'{32'h0000_F000, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0F00, 1'b0, 1'b0, 32'h0},
		'{32'h0000_00F0, 1'b0, 1'b0, 32'h0},
		'{32'h0000_000F, 1'b0, 1'b0, 32'h0},
		'{32'h0000_000F, 1'b0, 1'b0, 32'h0},
		'{32'h1234_5678, 1'b1, 1'b0, 32'h0},
		'{32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
		'{32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
		'{32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
		'{32'hA5A5_A5A5, 1'b1, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0003, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0001, 1'b1, 1'b0, 32'h0}
	};

	// Free-running clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Sort the held chunk by 4-bit digits, least significant first, and queue the results
	function automatic void sort_held_chunk();
		logic [lrcs_pkg::KEY_W-1:0] src [CHUNK];
		logic [lrcs_pkg::KEY_W-1:0] dst [CHUNK];
		int                         bucket [NBKT];
		int                         n;
		int                         d;
		sorted_t                    item;

		n = chunk_held.size();
		for (int i = 0; i < n; i++)
			src[i] = chunk_held[i];
		for (int p = 0; p < NPASS; p++) begin
			for (int b = 0; b < NBKT; b++)
				bucket[b] = 0;
			for (int i = 0; i < n; i++) begin
				d = int'((src[i] >> (p * lrcs_pkg::DIGIT_BITS_DEF))
					& lrcs_pkg::KEY_W'(NBKT - 1));
				bucket[d]++;
			end
			for (int b = 1; b < NBKT; b++)
				bucket[b] += bucket[b - 1];
			// Scatter back to front to keep equal digits in order
			for (int i = n - 1; i >= 0; i--) begin
				d = int'((src[i] >> (p * lrcs_pkg::DIGIT_BITS_DEF))
					& lrcs_pkg::KEY_W'(NBKT - 1));
				bucket[d]--;
				dst[bucket[d]] = src[i];
			end
			src = dst;
		end
		for (int i = 0; i < n; i++) begin
			item.key  = src[i];
			item.last = (i == n - 1);
			sorted_expected.push_back(item);
		end
		chunk_held.delete();
	endfunction

	// Offer one key after a random gap and track it once the transfer happens
	task automatic send_key(input logic [lrcs_pkg::KEY_W-1:0] k, input logic fin,
			input logic typed, input logic [lrcs_pkg::KEY_W-1:0] exp_key);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			key_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		key_ch.valid     <= 1'b1;
		key_ch.key       <= k;
		key_ch.final_key <= fin;
		do @(posedge clk); while (key_ch.ready !== 1'b1);
		if (typed) begin
			sorted_expected.push_back('{key: exp_key, last: 1'b1});
		end else begin
			chunk_held.push_back(k & KEY_MASK);
			if (fin || chunk_held.size() == CHUNK)
				sort_held_chunk();
		end
	endtask

	// Compare one sorted transfer against the oldest expectation
	task automatic check_sorted(input logic [lrcs_pkg::KEY_W-1:0] k, input logic last);
		sorted_t want;
		if (sorted_expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected sorted key %h last %b", k, last);
		end else begin
			want = sorted_expected.pop_front();
			if (want.key !== k || want.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: key exp %h got %h, last exp %b got %b",
						results_seen, want.key, k, want.last, last);
			end
		end
		results_seen++;
	endtask

	// Sink side: stall at random, hold off for long stretches twice
	initial begin
		int stall;
		sorted_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (results_seen == 30 || results_seen == 200)
				stall = LONG_HOLD;
			else
				stall = steady ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			if (stall > 0) begin
				sorted_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			sorted_ch.ready <= 1'b1;
			do @(posedge clk); while (sorted_ch.valid !== 1'b1);
			check_sorted(sorted_ch.sorted_key, sorted_ch.final_out);
		end
	end

	// Source side: reset, directed rows, random chunks, drain
	initial begin
		int                         sent;
		int                         chunk_idx;
		int                         n;
		int                         mode;
		int                         style;
		logic                       mark_full;
		logic [lrcs_pkg::KEY_W-1:0] k;

		arst_n           = 1'b0;
		key_ch.valid     = 1'b0;
		key_ch.key       = '0;
		key_ch.final_key = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		for (int r = 0; r < N_DIR; r++)
			send_key(dir_rows[r].key, dir_rows[r].fin, dir_rows[r].typed,
				dir_rows[r].exp_key);

		// Random chunks up to the item budget; the first is full without a mark,
		// the fourth full with one, and a chunk cut short by the budget is marked
		sent = 0;
		chunk_idx = 0;
		while (sent < N_ITEMS - N_DIR) begin
			mode = (chunk_idx == 0) ? 0 : (chunk_idx == 3) ? 1 : $urandom_range(0, 9);
			mark_full = (mode == 1);
			n = (mode <= 1) ? CHUNK : $urandom_range(1, 12);
			if (n > N_ITEMS - N_DIR - sent) begin
				n = N_ITEMS - N_DIR - sent;
				mark_full = 1'b1;
			end
			style = $urandom_range(0, 3);
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < n; i++) begin
				case (style)
					0: k = $urandom;
					1: k = {$urandom} & {8{4'($urandom_range(0, 15))}};
					2: k = lrcs_pkg::KEY_W'($urandom_range(0, 40));
					default: k = {4'($urandom_range(0, 15)), 28'($urandom)} & 32'hF000_00FF;
				endcase
				send_key(k, (i == n - 1) && (mode > 1 || mark_full), 1'b0, '0);
				sent++;
			end
			chunk_idx++;
		end
		steady = 0;
		@(negedge clk);
		key_ch.valid <= 1'b0;

		// Drain, then allow stray output to show up
		while (sorted_expected.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
